[rtl/core/udpdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// udpdf_pkg
// Shared types, constants and codes for the duplicate packet filter.
//------------------------------------------------------------------------------
package udpdf_pkg;

    // History ring geometry.
    localparam int HIST_DEPTH = 10;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    // Queue between the classifier and the history checker.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    // Packet format.
    localparam logic [10:0] GOOD_LENGTH  = 11'd14;
    localparam logic [31:0] START_MARK   = 32'h55AA66BB;
    localparam logic [31:0] END_MARK     = 32'hBB66AA55;
    localparam logic [15:0] WINDOW_RESET = 16'd5000;

    // Reject reason codes; a queued job carrying WHY_NONE still needs the history check.
    localparam logic [1:0] WHY_NONE    = 2'd0;
    localparam logic [1:0] WHY_LENGTH  = 2'd1;
    localparam logic [1:0] WHY_MARKERS = 2'd2;
    localparam logic [1:0] WHY_REPEAT  = 2'd3;

    // One classified packet waiting for the checker.
    typedef struct packed {
        logic [1:0]  why;
        logic [31:0] ip;
        logic [15:0] id;
        logic [7:0]  kind;
        logic [15:0] tag;
        logic [7:0]  data;
        logic [31:0] now;
    } t_job;

    // One history ring entry.
    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] id;
        logic [31:0] tick;
    } t_hist;

    // One result beat.
    typedef struct packed {
        logic        accepted;
        logic [1:0]  why;
        logic [7:0]  kind;
        logic [15:0] tag;
        logic [7:0]  data;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/udpdf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// udpdf_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
module udpdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/core/udpdf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// udpdf_front
// Accepts packet beats, checks length and markers, and queues the job.
//------------------------------------------------------------------------------
module udpdf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [10:0]   i_frame_length,
    input  wire logic [31:0]   i_start_flag,
    input  wire logic [31:0]   i_end_flag,
    input  wire logic [31:0]   i_source_ip,
    input  wire logic [15:0]   i_sequence_id,
    input  wire logic [7:0]    i_command_kind,
    input  wire logic [15:0]   i_control_tag,
    input  wire logic [7:0]    i_control_data,
    input  wire logic [31:0]   i_now_tick,
    output logic               o_job_valid,
    output udpdf_pkg::t_job    o_job,
    input  wire logic          i_job_pop
);

    udpdf_pkg::t_job r_q [udpdf_pkg::Q_DEPTH];
    logic [udpdf_pkg::Q_AW-1:0] r_wp;
    logic [udpdf_pkg::Q_AW-1:0] r_rp;
    logic [udpdf_pkg::Q_AW:0]   r_cnt;
    udpdf_pkg::t_job            w_job;
    logic                       w_push;
    logic                       w_pop;

    // Classify the incoming packet: length first, then the two markers.
    always_comb begin
        w_job.ip   = i_source_ip;
        w_job.id   = i_sequence_id;
        w_job.kind = i_command_kind;
        w_job.tag  = i_control_tag;
        w_job.data = i_control_data;
        w_job.now  = i_now_tick;
        if (i_frame_length != udpdf_pkg::GOOD_LENGTH) begin
            w_job.why = udpdf_pkg::WHY_LENGTH;
        end else if (i_start_flag != udpdf_pkg::START_MARK ||
                     i_end_flag != udpdf_pkg::END_MARK) begin
            w_job.why = udpdf_pkg::WHY_MARKERS;
        end else begin
            w_job.why = udpdf_pkg::WHY_NONE;
        end
    end

    assign o_ready     = (r_cnt != (udpdf_pkg::Q_AW+1)'(udpdf_pkg::Q_DEPTH));
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_job_pop && o_job_valid;

    // Queue payload storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + udpdf_pkg::Q_AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + udpdf_pkg::Q_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (udpdf_pkg::Q_AW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (udpdf_pkg::Q_AW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/udpdf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// udpdf_back
// Walks the history ring for each queued job, records new packets and
// holds the result beat until it is taken.
//------------------------------------------------------------------------------
module udpdf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [15:0]   i_window,
    input  wire logic          i_job_valid,
    input  wire udpdf_pkg::t_job i_job,
    output logic               o_job_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output udpdf_pkg::t_result o_result
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    localparam logic [udpdf_pkg::HIST_AW-1:0] LAST_IDX =
        udpdf_pkg::HIST_AW'(udpdf_pkg::HIST_DEPTH - 1);

    logic [1:0]                         r_state;
    udpdf_pkg::t_job                    r_job;
    logic [udpdf_pkg::HIST_AW-1:0]      r_idx;
    logic                               r_issue_done;
    logic                               r_cmp_v;
    logic                               r_cmp_last;
    logic                               r_cmp_vld;
    logic                               r_hit;
    logic [udpdf_pkg::HIST_AW-1:0]      r_wslot;
    logic [udpdf_pkg::HIST_DEPTH-1:0]   r_hist_vld;
    logic                               r_out_valid;
    udpdf_pkg::t_result                 r_out;

    logic                               w_can_load;
    logic                               w_issue;
    logic                               w_load;
    logic                               w_write;
    logic                               w_match;
    logic [31:0]                        w_age;
    logic [$bits(udpdf_pkg::t_hist)-1:0] w_rdata;
    udpdf_pkg::t_hist                   w_rd;
    udpdf_pkg::t_hist                   w_wr;
    udpdf_pkg::t_result                 n_out;

    assign w_can_load = !r_out_valid || i_ready;
    assign o_job_pop  = (r_state == ST_IDLE) && i_job_valid;
    assign w_issue    = (r_state == ST_SCAN) && !r_issue_done;
    assign w_load     = (r_state == ST_DECIDE) && w_can_load;
    assign w_write    = w_load && (r_job.why == udpdf_pkg::WHY_NONE) && !r_hit;

    // History storage, one entry read per cycle during the scan.
    assign w_wr.ip   = r_job.ip;
    assign w_wr.id   = r_job.id;
    assign w_wr.tick = r_job.now;

    udpdf_ram #(
        .WIDTH ($bits(udpdf_pkg::t_hist)),
        .DEPTH (udpdf_pkg::HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_write),
        .i_waddr (r_wslot),
        .i_wdata (w_wr),
        .i_re    (w_issue),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rd = w_rdata;

    // Entry comparison with the modular tick age.
    assign w_age   = r_job.now - w_rd.tick;
    assign w_match = r_cmp_v && r_cmp_vld && (w_rd.ip == r_job.ip) &&
                     (w_rd.id == r_job.id) && (w_age < {16'd0, i_window});

    // Result beat contents.
    always_comb begin
        n_out = '0;
        if (r_job.why != udpdf_pkg::WHY_NONE) begin
            n_out.why = r_job.why;
        end else if (r_hit) begin
            n_out.why = udpdf_pkg::WHY_REPEAT;
        end else begin
            n_out.accepted = 1'b1;
            n_out.why      = udpdf_pkg::WHY_NONE;
            n_out.kind     = r_job.kind;
            n_out.tag      = r_job.tag;
            n_out.data     = r_job.data;
        end
    end

    // Job payload and output payload registers.
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    // Sequencer, scan pipeline, ring pointer and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_cmp_v      <= 1'b0;
            r_cmp_last   <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_hit        <= 1'b0;
            r_wslot      <= '0;
            r_hist_vld   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cmp_v    <= w_issue;
            r_cmp_last <= w_issue && (r_idx == LAST_IDX);
            r_cmp_vld  <= r_hist_vld[r_idx];
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_idx        <= '0;
                    r_issue_done <= 1'b0;
                    r_hit        <= 1'b0;
                    if (i_job_valid) begin
                        if (i_job.why == udpdf_pkg::WHY_NONE) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_DECIDE;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_issue) begin
                        if (r_idx == LAST_IDX) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + udpdf_pkg::HIST_AW'(1);
                        end
                    end
                    if (w_match) begin
                        r_hit <= 1'b1;
                    end
                    if (r_cmp_v && r_cmp_last) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                    if (w_write) begin
                        r_hist_vld[r_wslot] <= 1'b1;
                        if (r_wslot == LAST_IDX) begin
                            r_wslot <= '0;
                        end else begin
                            r_wslot <= r_wslot + udpdf_pkg::HIST_AW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    // The ring write pointer never leaves the ring.
    a_wslot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wslot <= LAST_IDX)
        else $error("history write pointer out of range");

    // A packet is recorded only when it passed every check.
    a_write_only_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_write |-> (r_state == ST_DECIDE && r_job.why == udpdf_pkg::WHY_NONE && !r_hit))
        else $error("history written for a rejected packet");

    // Recording a packet marks its slot valid on the next cycle.
    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_write |=> r_hist_vld[$past(r_wslot)])
        else $error("recorded slot not marked valid");

    // An accepted result never carries a reject reason.
    a_accept_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.accepted) |-> (r_out.why == udpdf_pkg::WHY_NONE))
        else $error("accepted beat with a reject reason");

    // A loaded result is held until the sink takes it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_load)
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

[rtl/core/udp_duplicate_packet_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// udp_duplicate_packet_filter
// Command packet filter with length, marker and recent-duplicate checks.
//------------------------------------------------------------------------------
// Each input beat is one received command packet and gives exactly one result
// beat, in order. The front stage checks length and markers in the accepting
// cycle and queues the packet (two entries deep). The back stage then reads
// the history RAM through its single read port, one entry per cycle, and a
// well formed packet holds it until every entry is compared; a packet
// rejected for length or markers skips the scan. The result beat sits in
// an output register, so the sink may stall without stopping the queue from
// filling. tuser carries the verdict, tdata the command fields, which read as
// zero for a rejected packet. The duplicate window must be written through
// i_cfg_we only while the block is idle; the block does not enforce this.
//------------------------------------------------------------------------------
module udp_duplicate_packet_filter (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Duplicate window in ticks.
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_wdata,
    // Packet input.
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // frame_length[10:0], start_flag[42:11], end_flag[74:43], source_ip[106:75],
    // sequence_id[122:107], command_kind[130:123], control_tag[146:131],
    // control_data[154:147], now_tick[186:155], zero fill[191:187]
    input  wire logic [191:0] i_s_axis_tdata,
    // Result output.
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // out_kind[7:0], out_tag[23:8], out_data[31:24]
    output logic [31:0]       o_m_axis_tdata,
    // accepted[0], reject_reason[2:1]
    output logic [2:0]        o_m_axis_tuser
);

    logic [15:0]        r_window;
    logic               w_job_valid;
    logic               w_job_pop;
    udpdf_pkg::t_job    w_job;
    udpdf_pkg::t_result w_result;

    // Window register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= udpdf_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    udpdf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_frame_length (i_s_axis_tdata[10:0]),
        .i_start_flag   (i_s_axis_tdata[42:11]),
        .i_end_flag     (i_s_axis_tdata[74:43]),
        .i_source_ip    (i_s_axis_tdata[106:75]),
        .i_sequence_id  (i_s_axis_tdata[122:107]),
        .i_command_kind (i_s_axis_tdata[130:123]),
        .i_control_tag  (i_s_axis_tdata[146:131]),
        .i_control_data (i_s_axis_tdata[154:147]),
        .i_now_tick     (i_s_axis_tdata[186:155]),
        .o_job_valid    (w_job_valid),
        .o_job          (w_job),
        .i_job_pop      (w_job_pop)
    );

    udpdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_window    (r_window),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_result    (w_result)
    );

    // Result beat packing.
    assign o_m_axis_tdata = {w_result.data, w_result.tag, w_result.kind};
    assign o_m_axis_tuser = {w_result.why, w_result.accepted};

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the duplicate suppressing command packet filter.
//------------------------------------------------------------------------------
// Command packets go in as beats on the slave stream. Every result beat on the
// master stream is compared with a verdict that a small scoreboard predicts
// from its own history ring and window. The run starts with directed packets
// that cover the length, marker and duplicate checks, then several window
// settings with mostly well formed, often repeated packets, under random
// source and sink stalls. The last phase runs without stalls.
//------------------------------------------------------------------------------
module tb;
    import udpdf_pkg::*;

    // One packet as it sits on the input tdata bus, top field first.
    typedef struct packed {
        logic [4:0]  fill;
        logic [31:0] now;
        logic [7:0]  data;
        logic [15:0] tag;
        logic [7:0]  kind;
        logic [15:0] id;
        logic [31:0] ip;
        logic [31:0] end_word;
        logic [31:0] start_word;
        logic [10:0] len;
    } t_packet;

    // Scoreboard: holds a copy of the history ring and the expected verdicts.
    class filter_scoreboard;
        logic [15:0] window;
        bit          hist_valid [HIST_DEPTH];
        logic [31:0] hist_ip    [HIST_DEPTH];
        logic [15:0] hist_id    [HIST_DEPTH];
        logic [31:0] hist_tick  [HIST_DEPTH];
        int          write_slot;
        t_result     pending_verdicts [$];
        int          errors;
        int          n_accept;
        int          n_length;
        int          n_marker;
        int          n_repeat;

        function new();
            window = WINDOW_RESET;
            foreach (hist_valid[k]) begin
                hist_valid[k] = 1'b0;
                hist_ip[k]    = '0;
                hist_id[k]    = '0;
                hist_tick[k]  = '0;
            end
            write_slot = 0;
            errors     = 0;
            n_accept   = 0;
            n_length   = 0;
            n_marker   = 0;
            n_repeat   = 0;
        endfunction

        // A sender and id match a valid entry whose modular age is below the window.
        function bit seen_within_window(logic [31:0] ip, logic [15:0] id, logic [31:0] now);
            logic [31:0] age;
            for (int k = 0; k < HIST_DEPTH; k++) begin
                age = now - hist_tick[k];
                if (hist_valid[k] && hist_ip[k] == ip && hist_id[k] == id &&
                    age < {16'd0, window})
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Work out the verdict of an accepted packet and update the ring.
        function void note_packet(t_packet p);
            t_result r;
            r = '0;
            if (p.len != GOOD_LENGTH) begin
                r.why = WHY_LENGTH;
                n_length++;
            end else if (p.start_word != START_MARK || p.end_word != END_MARK) begin
                r.why = WHY_MARKERS;
                n_marker++;
            end else if (seen_within_window(p.ip, p.id, p.now)) begin
                r.why = WHY_REPEAT;
                n_repeat++;
            end else begin
                hist_valid[write_slot] = 1'b1;
                hist_ip[write_slot]    = p.ip;
                hist_id[write_slot]    = p.id;
                hist_tick[write_slot]  = p.now;
                write_slot             = (write_slot + 1) % HIST_DEPTH;
                r.accepted = 1'b1;
                r.why      = WHY_NONE;
                r.kind     = p.kind;
                r.tag      = p.tag;
                r.data     = p.data;
                n_accept++;
            end
            pending_verdicts.push_back(r);
        endfunction

        function void check_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            end
        endfunction

        // Compare one result beat with the oldest expected verdict.
        function void check_verdict(logic [31:0] tdata, logic [2:0] tuser);
            t_result want;
            if (pending_verdicts.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, tuser 0x%0h tdata 0x%0h",
                         $time, tuser, tdata);
                return;
            end
            want = pending_verdicts.pop_front();
            check_field("accepted", 16'(want.accepted), 16'(tuser[0]));
            check_field("reject_reason", 16'(want.why), 16'(tuser[2:1]));
            check_field("out_kind", 16'(want.kind), 16'(tdata[7:0]));
            check_field("out_tag", want.tag, tdata[23:8]);
            check_field("out_data", 16'(want.data), 16'(tdata[31:24]));
        endfunction
    endclass

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    t_packet     s_tdata   = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    filter_scoreboard scoreboard = new();

    // Stimulus state.
    bit          idle_on    = 1'b1;
    int          sink_stall = 0;
    int          window_set = WINDOW_RESET;
    int          n_windows  = 1;
    logic [31:0] tick_now   = '0;
    logic [31:0] ip_pool [4];
    logic [15:0] id_pool [4];
    logic [31:0] last_ip    = '0;
    logic [15:0] last_id    = '0;
    logic [31:0] last_tick  = '0;

    udp_duplicate_packet_filter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sink side: stalls in bursts of random length while idling is on.
    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            sink_stall <= $urandom_range(0, 7);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: register writes, accepted packets and result beats.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_we)
                scoreboard.window = cfg_wdata;
            if (s_tvalid && s_tready)
                scoreboard.note_packet(s_tdata);
            if (m_tvalid && m_tready)
                scoreboard.check_verdict(m_tdata, m_tuser);
        end
    end

    // Drive one packet beat, with an occasional gap before it.
    task automatic send_packet(input t_packet p);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // Wait until every expected verdict has come, then let the block settle.
    task automatic wait_drained(input int tail);
        @(posedge i_clk);
        while (scoreboard.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    function automatic t_packet good_packet(input logic [31:0] ip, input logic [15:0] id,
                                            input logic [31:0] tick);
        t_packet p;
        p            = '0;
        p.len        = GOOD_LENGTH;
        p.start_word = START_MARK;
        p.end_word   = END_MARK;
        p.ip         = ip;
        p.id         = id;
        p.now        = tick;
        p.kind       = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
        p.tag        = 16'($urandom);
        p.data       = 8'($urandom);
        return p;
    endfunction

    // Move the arrival tick: mostly small steps, sometimes past the window or a jump.
    task automatic advance_tick();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: tick_now += 32'($urandom_range(0, window_set / 4));
            5:          tick_now += 32'($urandom_range(window_set, 2 * window_set + 1));
            6:          tick_now = $urandom;
            7:          tick_now = 32'hFFFF_FFFF - 32'($urandom_range(0, window_set));
            default:    tick_now += 32'($urandom_range(0, 3));
        endcase
    endtask

    // Random packets: mostly well formed from a small pool of senders and ids.
    task automatic send_random(input int count);
        t_packet p;
        int      pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            advance_tick();
            p = good_packet(ip_pool[$urandom_range(0, 3)], id_pool[$urandom_range(0, 3)],
                            tick_now);
            if (pick >= 70 && pick < 78) begin
                // Resend of the last packet right at the window edge.
                p.ip  = last_ip;
                p.id  = last_id;
                p.now = last_tick + 32'(window_set) - 32'($urandom_range(0, 1));
            end else if (pick >= 78 && pick < 86) begin
                p.len = 11'($urandom_range(0, 2047));
                if (p.len == GOOD_LENGTH)
                    p.len = GOOD_LENGTH + 11'd1;
            end else if (pick >= 86 && pick < 94) begin
                if ($urandom_range(0, 1) == 0)
                    p.start_word ^= 32'd1 << $urandom_range(0, 31);
                else
                    p.end_word = $urandom;
            end else if (pick >= 94) begin
                p.len        = 11'($urandom);
                p.start_word = $urandom;
                p.end_word   = $urandom;
                p.ip         = $urandom;
                p.id         = 16'($urandom);
                p.kind       = 8'($urandom);
                p.now        = $urandom;
            end
            if (pick < 78) begin
                last_ip   = p.ip;
                last_id   = p.id;
                last_tick = p.now;
            end
            send_packet(p);
        end
    endtask

    // One phase: write the window while idle, then send a resend pair and random packets.
    task automatic run_phase(input logic [15:0] w, input int count);
        t_packet p;
        stop_sending();
        wait_drained(4);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        window_set = w;
        n_windows++;
        p = good_packet($urandom, 16'($urandom), tick_now);
        send_packet(p);
        send_packet(p);
        send_random(count);
    endtask

    task automatic send_directed();
        t_packet p;
        // An invalid entry never matches, even an all zero packet.
        p = good_packet('0, '0, '0);
        p.kind = '0; p.tag = '0; p.data = '0;
        send_packet(p);
        // Accept, repeat just inside the window, accept again at the edge.
        p = good_packet(32'hC0A8_0001, 16'd1, 32'd100);
        p.kind = 8'd1; p.tag = 16'hFFFF; p.data = 8'hFF;
        send_packet(p);
        send_packet(good_packet(32'hC0A8_0001, 16'd1, 32'd5099));
        send_packet(good_packet(32'hC0A8_0001, 16'd1, 32'd5100));
        // Same id from another sender, another id from the same sender.
        send_packet(good_packet(32'h0A00_0002, 16'd1, 32'd5100));
        send_packet(good_packet(32'hC0A8_0001, 16'd2, 32'd5100));
        // Length faults.
        foreach (ip_pool[k]) begin
            p = good_packet(32'hC0A8_0001, 16'd9, 32'd5100);
            p.len = (k == 0) ? 11'd0 : (k == 1) ? 11'h7FF : (k == 2) ? 11'd13 : 11'd15;
            send_packet(p);
        end
        // Marker faults, alone and together with other faults.
        p = good_packet(32'hC0A8_0001, 16'd9, 32'd5100);
        p.start_word = ~START_MARK;
        send_packet(p);
        p = good_packet(32'hC0A8_0001, 16'd9, 32'd5100);
        p.end_word = '0;
        send_packet(p);
        p.len = 11'd0;
        send_packet(p);
        p = good_packet(32'hC0A8_0001, 16'd2, 32'd5101);
        p.start_word = 32'hFFFF_FFFF;
        send_packet(p);
        p = good_packet(32'hC0A8_0001, 16'd2, 32'd5101);
        p.kind = 8'hFF;
        send_packet(p);
        // Age measured across the wrap of the tick counter.
        p = good_packet(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFF0);
        p.kind = 8'hFF;
        send_packet(p);
        send_packet(good_packet(32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0010));
        // A tick behind the stored one is a huge age, so no duplicate.
        send_packet(good_packet(32'h0A00_0002, 16'd7, 32'd1000));
        send_packet(good_packet(32'h0A00_0002, 16'd7, 32'd500));
        // Command kinds other than status and operation pass unchanged.
        p = good_packet(32'h0A00_0002, 16'd7, 32'hFFFF_FFFF);
        p.kind = 8'h80;
        send_packet(p);
    endtask

    // Main sequence.
    initial begin
        foreach (ip_pool[k]) begin
            ip_pool[k] = $urandom;
            id_pool[k] = 16'($urandom);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_directed();
        run_phase(16'd1, 75);
        run_phase(16'hFFFF, 75);
        run_phase(16'd0, 60);
        run_phase(16'($urandom_range(2, 65534)), 75);
        idle_on = 1'b0;
        run_phase(WINDOW_RESET, 75);
        stop_sending();
        wait_drained(32);
        $display("Checked %0d packets under %0d window settings: %0d accepted,",
                 scoreboard.n_accept + scoreboard.n_length + scoreboard.n_marker +
                 scoreboard.n_repeat, n_windows, scoreboard.n_accept);
        $display("%0d bad length, %0d bad markers, %0d duplicates, %0d mismatches.",
                 scoreboard.n_length, scoreboard.n_marker, scoreboard.n_repeat,
                 scoreboard.errors);
        if (scoreboard.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2ms;
        $display("Timeout with %0d verdicts outstanding.", scoreboard.pending_verdicts.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
